FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ms_pkg.sv
package ms_pkg;

	typedef struct packed {
		logic signed [31:0] key_in;
		logic               load_last;
	} load_t;

	typedef struct packed {
		logic signed [31:0] key_out;
		logic               out_last;
		logic               overflow;
	} result_t;

endpackage

FILE: hw/rtl/merge_sorter.sv
// Merge sorter. Keys arrive on the load channel one request at a time and are
// stored in order. The request with load_last set is stored too (unless the
// store is full) and starts an ascending, stable merge sort over the set.
// The sorted keys then leave on the result channel, one per request, with
// out_last on the final key and overflow set on every key of a set in which
// a key was dropped because the store already held MAX_KEYS entries.
// Keys are compared as KEY_WIDTH-bit signed values.
// For a set of n keys the sort runs ceil(log2 n) passes, each a priming step
// and then one compare per written key on a single comparator that reads two
// heads from a ping-pong pair of memories; after the last pass (after the last
// load when n is 1) an output priming step reads the first key. Results then
// leave at one per cycle while result_ready is high.
// load_ready is low from the last load until the final result is taken.
// A stalled result holds its value until taken. Reset empties the set and
// clears the overflow mark; the key memories need no clearing.
module merge_sorter #(
	parameter int MAX_KEYS  = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	output logic              load_ready,
	input  ms_pkg::load_t     load,
	output logic              result_valid,
	input  logic              result_ready,
	output ms_pkg::result_t   result
);

	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int AW = $clog2(MAX_KEYS);
	localparam int EW = CW + 2;
	localparam int KW = KEY_WIDTH;
	localparam logic [CW-1:0] MAXC = CW'(MAX_KEYS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PRIME  = 3'd1;
	localparam logic [2:0] S_MERGE  = 3'd2;
	localparam logic [2:0] S_OPRIME = 3'd3;
	localparam logic [2:0] S_OUT    = 3'd4;

	function automatic logic [EW-1:0] umin(input logic [EW-1:0] x, input logic [EW-1:0] y);
		return (x < y) ? x : y;
	endfunction

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          par_q;
	logic [CW-1:0] n_q;
	logic [EW-1:0] w_q, a_q, b_q, k_q, mid_q, hi_q;
	logic [AW-1:0] idx_q;

	logic [KW-1:0] mem0 [MAX_KEYS];
	logic [KW-1:0] mem1 [MAX_KEYS];
	logic [KW-1:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;

	logic          load_fire, out_fire, full, out_last;
	logic [63:0]   key_sx;
	logic [KW-1:0] key_w, ka, kb, merge_wd, wd;
	logic [KW+31:0] out_ext;
	logic [CW-1:0] count_n;
	logic [EW-1:0] n_ext, k_n, a_n, b_n, w_n, mid_n, hi_n;
	logic          a_ok, b_ok, take_a, seg_end, pass_end, sort_done;
	logic [AW-1:0] ra, rb, wa;
	logic          we0, we1;

	assign load_ready   = (state_q == S_IDLE);
	assign result_valid = (state_q == S_OUT);
	assign load_fire    = load_valid && load_ready;
	assign out_fire     = result_valid && result_ready;
	assign full         = (count_q == MAXC);
	assign count_n      = full ? count_q : count_q + CW'(1);

	assign key_sx = {{32{load.key_in[31]}}, load.key_in};
	assign key_w  = key_sx[KW-1:0];

	assign ka = par_q ? rd1a_q : rd0a_q;
	assign kb = par_q ? rd1b_q : rd0b_q;

	// Merge step: the left head wins ties, and an exhausted run never wins.
	assign n_ext    = EW'(n_q);
	assign a_ok     = (a_q < mid_q);
	assign b_ok     = (b_q < hi_q);
	assign take_a   = a_ok && (!b_ok || ($signed(ka) <= $signed(kb)));
	assign merge_wd = take_a ? ka : kb;
	assign k_n      = k_q + EW'(1);
	assign seg_end  = (k_n == hi_q);
	assign pass_end = (k_n == n_ext);
	assign w_n      = w_q << 1;
	assign sort_done = (w_n >= n_ext);

	always_comb begin
		a_n   = take_a ? a_q + EW'(1) : a_q;
		b_n   = take_a ? b_q : b_q + EW'(1);
		mid_n = mid_q;
		hi_n  = hi_q;
		if (pass_end) begin
			a_n   = '0;
			b_n   = w_n;
			mid_n = umin(w_n, n_ext);
			hi_n  = umin(w_n << 1, n_ext);
		end else if (seg_end) begin
			a_n   = hi_q;
			mid_n = umin(hi_q + w_q, n_ext);
			hi_n  = umin(hi_q + (w_q << 1), n_ext);
			b_n   = mid_n;
		end
	end

	assign out_last = (CW'(idx_q) + CW'(1) == n_q);

	// Read addresses look one step ahead so that data is ready in the next cycle.
	always_comb begin
		ra = a_q[AW-1:0];
		rb = b_q[AW-1:0];
		if (state_q == S_MERGE) begin
			ra = a_n[AW-1:0];
			rb = b_n[AW-1:0];
		end else if (state_q == S_OPRIME) begin
			ra = idx_q;
		end else if (state_q == S_OUT) begin
			ra = (out_fire && !out_last) ? idx_q + AW'(1) : idx_q;
		end
	end

	always_comb begin
		we0 = 1'b0;
		we1 = 1'b0;
		wa  = k_q[AW-1:0];
		wd  = merge_wd;
		if (load_fire) begin
			we0 = !full;
			wa  = count_q[AW-1:0];
			wd  = key_w;
		end else if (state_q == S_MERGE) begin
			we0 = par_q;
			we1 = !par_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we0) begin
			mem0[wa] <= wd;
		end
		rd0a_q <= mem0[ra];
		rd0b_q <= mem0[rb];
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			mem1[wa] <= wd;
		end
		rd1a_q <= mem1[ra];
		rd1b_q <= mem1[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			par_q   <= 1'b0;
			n_q     <= '0;
			w_q     <= '0;
			a_q     <= '0;
			b_q     <= '0;
			k_q     <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (load_fire) begin
						count_q <= count_n;
						ovf_q   <= ovf_q | full;
						if (load.load_last) begin
							n_q   <= count_n;
							par_q <= 1'b0;
							idx_q <= '0;
							w_q   <= EW'(1);
							a_q   <= '0;
							b_q   <= EW'(1);
							mid_q <= EW'(1);
							hi_q  <= EW'(2);
							k_q   <= '0;
							state_q <= (count_n == CW'(1)) ? S_OPRIME : S_PRIME;
						end
					end
				end
				S_PRIME: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					a_q   <= a_n;
					b_q   <= b_n;
					mid_q <= mid_n;
					hi_q  <= hi_n;
					k_q   <= pass_end ? '0 : k_n;
					if (pass_end) begin
						w_q   <= w_n;
						par_q <= !par_q;
						state_q <= sort_done ? S_OPRIME : S_PRIME;
					end
				end
				S_OPRIME: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_fire) begin
						if (out_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ext         = {32'b0, ka};
	assign result.key_out  = out_ext[31:0];
	assign result.out_last = out_last;
	assign result.overflow = ovf_q;

endmodule

FILE: hw/rtl/ms_checker.sv
`include "assert_macros.svh"

module ms_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            load_valid,
	input logic            load_ready,
	input ms_pkg::load_t   load,
	input logic            result_valid,
	input logic            result_ready,
	input ms_pkg::result_t result
);

	// The block never loads while a sorted set is draining.
	`ASSERT_IMP(a_excl, load_ready, !result_valid, "load and result channels both open")

	// The final key of a set closes the load channel.
	`ASSERT_NXT(a_close, load_valid && load_ready && load.load_last, !load_ready, "still ready after last key")

	// Once the final sorted key is taken, no further result follows at once.
	`ASSERT_NXT(a_end, result_valid && result_ready && result.out_last, !result_valid, "result after final key")

	// Within a set the next key follows immediately with the same overflow mark.
	`ASSERT_NXT(a_ovf, result_valid && result_ready && !result.out_last, result_valid && (result.overflow == $past(result.overflow)), "overflow mark changed within a set")

	`ASSERT_NXT(a_hold, result_valid && !result_ready, result_valid && $stable(result), "stalled result changed")

endmodule

bind merge_sorter ms_checker u_ms_checker (.*);

FILE: bench/merge_sorter_tb.sv
// Holds the keys of the set being loaded and the sorted results that must come out.
class sort_scoreboard;
	logic signed [31:0] held_keys[$];
	bit                 set_dropped;
	ms_pkg::result_t    sorted_q[$];
	int                 errors;
	int                 capacity;

	function new(int max_keys);
		capacity    = max_keys;
		set_dropped = 1'b0;
		errors      = 0;
	endfunction

	function void note_load(ms_pkg::load_t req);
		logic signed [31:0] run[$];
		logic signed [31:0] v;
		ms_pkg::result_t    r;
		int                 i;
		int                 j;
		if (held_keys.size() < capacity) begin
			held_keys.push_back(req.key_in);
		end else begin
			set_dropped = 1'b1;
		end
		if (!req.load_last)
			return;
		// Insertion sort keeps equal keys in arrival order.
		run = held_keys;
		for (i = 1; i < run.size(); i++) begin
			v = run[i];
			j = i - 1;
			while (j >= 0 && run[j] > v) begin
				run[j + 1] = run[j];
				j--;
			end
			run[j + 1] = v;
		end
		for (i = 0; i < run.size(); i++) begin
			r.key_out  = run[i];
			r.out_last = (i == run.size() - 1);
			r.overflow = set_dropped;
			sorted_q.push_back(r);
		end
		held_keys.delete();
		set_dropped = 1'b0;
	endfunction

	function void report(string what, ms_pkg::result_t want, ms_pkg::result_t got);
		errors++;
		if (errors <= 10)
			$display("%s: expected key %h last %b ovf %b, got key %h last %b ovf %b", what,
				want.key_out, want.out_last, want.overflow,
				got.key_out, got.out_last, got.overflow);
	endfunction

	function void check_result(ms_pkg::result_t got);
		ms_pkg::result_t want;
		if (sorted_q.size() == 0) begin
			want = '0;
			report("unexpected result", want, got);
			return;
		end
		want = sorted_q.pop_front();
		if (got.key_out !== want.key_out || got.out_last !== want.out_last ||
			got.overflow !== want.overflow)
			report("result mismatch", want, got);
	endfunction

	function int outstanding();
		return sorted_q.size();
	endfunction
endclass

module merge_sorter_tb;

	localparam int MAX_KEYS = 64;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            load_valid = 1'b0;
	logic            load_ready;
	ms_pkg::load_t   load = '0;
	logic            result_valid;
	logic            result_ready = 1'b0;
	ms_pkg::result_t result;

	sort_scoreboard sb = new(MAX_KEYS);
	int burst_left = 0;
	int items_sent = 0;

	merge_sorter #(.MAX_KEYS(MAX_KEYS), .KEY_WIDTH(32)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (load_valid),
		.load_ready   (load_ready),
		.load         (load),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// Offers one key and returns at the edge that accepts it, then maybe pauses.
	task automatic send_key(input logic signed [31:0] k, input logic last);
		ms_pkg::load_t req;
		int            gap;
		req.key_in    = k;
		req.load_last = last;
		load_valid <= 1'b1;
		load       <= req;
		@(posedge clk);
		while (!load_ready)
			@(posedge clk);
		sb.note_load(req);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 12) : $urandom_range(0, 2);
			if (gap > 0) begin
				load_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	function automatic logic signed [31:0] random_key();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return raw;
			5, 6:          return $signed($urandom_range(0, 15)) - 8;
			7: begin
				case (raw[1:0])
					2'd0: return KEY_MIN;
					2'd1: return KEY_MAX;
					2'd2: return '0;
					default: return -1;
				endcase
			end
			8:       return ($signed($urandom_range(0, 63)) - 32) <<< 16;
			default: return KEY_MAX - $signed($urandom_range(0, 3));
		endcase
	endfunction

	task automatic send_random_set(input int n);
		int i;
		for (i = 0; i < n; i++)
			send_key(random_key(), i == n - 1);
	endtask

	initial begin : stimulus
		int r;
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-key sets at both extremes.
		send_key(KEY_MIN, 1'b1);
		send_key(KEY_MAX, 1'b1);
		// Extremes mixed with ties.
		send_key(32'sd0, 1'b0);
		send_key(-32'sd1, 1'b0);
		send_key(KEY_MAX, 1'b0);
		send_key(KEY_MIN, 1'b0);
		send_key(32'sd1, 1'b0);
		send_key(-32'sd1, 1'b0);
		send_key(32'sh0001_0000, 1'b0);
		send_key(KEY_MIN, 1'b1);
		// Descending input.
		for (int k = 3; k >= -3; k--)
			send_key(k <<< 16, k == -3);
		// Two equal keys.
		send_key(32'sd5, 1'b0);
		send_key(32'sd5, 1'b1);

		// A full store, then a set that overflows it, with the last key dropped.
		send_random_set(MAX_KEYS);
		send_random_set(MAX_KEYS + $urandom_range(1, 3));
		while (items_sent < 370) begin
			r = $urandom_range(0, 29);
			if (r == 0)
				n = MAX_KEYS;
			else if (r == 1)
				n = MAX_KEYS + $urandom_range(1, 3);
			else if (r < 7)
				n = $urandom_range(9, 32);
			else
				n = $urandom_range(1, 8);
			send_random_set(n);
		end
		load_valid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Result side: random stall modes, plus two long hold-offs that back up the load side.
	initial begin : drain
		int taken;
		int hold;
		int mode;
		int mode_left;
		taken     = 0;
		hold      = 0;
		mode      = 0;
		mode_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				sb.check_result(result);
				taken++;
				if (taken == 20 || taken == 250)
					hold = 400;
			end
			if (hold > 0) begin
				result_ready <= 1'b0;
				hold--;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 2);
					mode_left = $urandom_range(5, 60);
				end
				mode_left--;
				case (mode)
					0:       result_ready <= 1'b1;
					1:       result_ready <= ($urandom_range(0, 1) == 1);
					default: result_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end
endmodule
